// ===== sv/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared widths, codes and controller/datapath interface types for the
// slot free list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

   localparam int MAX_SLOTS  = 64;
   localparam int ID_W       = 7;
   localparam int COUNT_W    = ID_W;
   localparam int SIZE_W     = 17;
   localparam int OFFSET_W   = 22;
   localparam int ADDR_W     = $clog2(MAX_SLOTS + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_SLOTS);
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(64);
   localparam logic [SIZE_W-1:0]  SIZE_LIMIT  = SIZE_W'(65536);

   localparam logic REG_SLOT_COUNT = 1'b0;
   localparam logic REG_SLOT_SIZE  = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_LIST  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_INVALID   = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RD_REQ,
      RD_ZERO,
      RD_DATA,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_HEAD_LINK,
      WR_CLEAR,
      WR_FREE_LINK,
      WR_FREE_HEAD
   } wr_sel_type;

   typedef enum logic [1:0] {
      ID_NONE,
      ID_HEAD,
      ID_REQ,
      ID_PEND
   } id_sel_type;

   typedef struct packed {
      logic       start;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       pend_load;
      logic       emit;
      status_type emit_status;
      id_sel_type id_sel;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   id_ok;
      logic   rd_zero;
      logic   head_ok;
      logic   list_end;
      logic   pend_valid;
      logic   out_free;
   } sts_type;

endpackage

// ===== sv/sfla_ram.sv =====
// ----------------------------------------------------------------------------
// sfla_ram
// Generic one write port, one read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sfla_csr.sv =====
// ----------------------------------------------------------------------------
// sfla_csr
// Configuration registers: slot count and slot size, with clamping on write.
// ----------------------------------------------------------------------------
module sfla_csr import sfla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [COUNT_W-1:0]    slot_count,
   output logic [SIZE_W-1:0]     slot_size,
   output logic                  init
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic               wr_stb;
   logic               reg_idx;
   logic [COUNT_W-1:0] wr_count;
   logic [SIZE_W-1:0]  wr_size;

   assign wr_stb   = psel && penable && pwrite;
   assign reg_idx  = paddr[2];
   assign wr_count = pwdata[COUNT_W-1:0];
   assign wr_size  = pwdata[SIZE_W-1:0];

   always_comb begin
      count_in = count_ff;
      size_in  = size_ff;
      if (wr_stb && reg_idx == REG_SLOT_COUNT) begin
         if (wr_count == '0) begin
            count_in = COUNT_W'(1);
         end else if (wr_count > COUNT_W'(MAX_SLOTS)) begin
            count_in = COUNT_W'(MAX_SLOTS);
         end else begin
            count_in = wr_count;
         end
      end
      if (wr_stb && reg_idx == REG_SLOT_SIZE) begin
         size_in = (wr_size > SIZE_LIMIT) ? SIZE_LIMIT : wr_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         size_ff  <= SIZE_RESET;
      end else begin
         count_ff <= count_in;
         size_ff  <= size_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SLOT_COUNT: prdata = CSR_DATA_W'(count_ff);
         REG_SLOT_SIZE:  prdata = CSR_DATA_W'(size_ff);
         default:        prdata = '0;
      endcase
   end

   assign pready     = 1'b1;
   assign slot_count = count_ff;
   assign slot_size  = size_ff;
   assign init       = wr_stb && reg_idx == REG_SLOT_COUNT;

endmodule

// ===== sv/sfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfla_ctrl
// Operation sequencer: steps table reads and writes and result transfers.
// ----------------------------------------------------------------------------
module sfla_ctrl import sfla_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_operation,
   output logic          req_stall,
   input  sts_type       sts,
   output cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_ALLOC2,
      S_ALLOC3,
      S_FREE2,
      S_FREE3,
      S_LIST,
      S_LIST_END
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      cmd.start       = 1'b0;
      cmd.rd_en       = 1'b0;
      cmd.rd_sel      = RD_REQ;
      cmd.wr_en       = 1'b0;
      cmd.wr_sel      = WR_HEAD_LINK;
      cmd.pend_load   = 1'b0;
      cmd.emit        = 1'b0;
      cmd.emit_status = ST_OK;
      cmd.id_sel      = ID_NONE;
      cmd.emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               cmd.rd_en = 1'b1;
               state_in  = (op_type'(req_operation) == OP_LIST) ? S_LIST : S_EXEC;
            end
         end
         S_EXEC: begin
            case (sts.op)
               OP_ALLOC: begin
                  if (sts.head_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_DATA;
                     state_in   = S_ALLOC2;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = ST_NO_FREE;
                     state_in        = S_IDLE;
                  end
               end
               OP_FREE: begin
                  if (sts.id_ok && sts.rd_zero) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_ZERO;
                     state_in   = S_FREE2;
                  end else if (sts.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = sts.id_ok ? ST_OK : ST_INVALID;
                     state_in        = S_IDLE;
                  end
               end
               OP_QUERY: begin
                  if (sts.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                     if (!sts.id_ok) begin
                        cmd.emit_status = ST_INVALID;
                     end else if (!sts.rd_zero) begin
                        cmd.emit_status = ST_NOT_ALLOC;
                     end else begin
                        cmd.id_sel = ID_REQ;
                     end
                  end
               end
               default: begin
                  state_in = S_LIST;
               end
            endcase
         end
         S_ALLOC2: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_HEAD_LINK;
            state_in   = S_ALLOC3;
         end
         S_ALLOC3: begin
            if (sts.out_free) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_CLEAR;
               cmd.emit   = 1'b1;
               cmd.id_sel = ID_HEAD;
               state_in   = S_IDLE;
            end
         end
         S_FREE2: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_FREE_LINK;
            state_in   = S_FREE3;
         end
         S_FREE3: begin
            if (sts.out_free) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_FREE_HEAD;
               cmd.emit   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_LIST: begin
            // one used id is held back so the final one can carry last
            if (!(sts.rd_zero && sts.pend_valid && !sts.out_free)) begin
               cmd.pend_load = sts.rd_zero;
               cmd.emit      = sts.rd_zero && sts.pend_valid;
               cmd.id_sel    = ID_PEND;
               cmd.emit_last = 1'b0;
               if (sts.list_end) begin
                  state_in = S_LIST_END;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end
         end
         S_LIST_END: begin
            if (sts.out_free) begin
               cmd.emit   = 1'b1;
               cmd.id_sel = sts.pend_valid ? ID_PEND : ID_NONE;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/sfla_dp.sv =====
// ----------------------------------------------------------------------------
// sfla_dp
// Datapath: link table with per-entry valid bits, item registers, list
// walk counter, offset multiplier and the result register.
// ----------------------------------------------------------------------------
module sfla_dp import sfla_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_operation,
   input  logic [ID_W-1:0]     req_slot_id,
   input  logic [COUNT_W-1:0]  slot_count,
   input  logic [SIZE_W-1:0]   slot_size,
   input  logic                init,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [OFFSET_W-1:0] rsp_offset,
   output logic                rsp_valid_res,
   output logic                rsp_last
);

   localparam int PROD_W = SIZE_W + ID_W;

   logic [MAX_SLOTS:0]  vld_ff;
   logic                vld_q_ff;
   logic [ADDR_W-1:0]   addr_q_ff;
   op_type              op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [ID_W-1:0]     head_ff;
   logic [ADDR_W-1:0]   idx_ff;
   logic                pend_valid_ff;
   logic [ADDR_W-1:0]   pend_id_ff;

   logic                rsp_valid_ff;
   logic [1:0]          status_ff;
   logic [ID_W-1:0]     result_id_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic                valid_res_ff;
   logic                last_ff;

   logic [ADDR_W-1:0]   rd_addr;
   logic [ID_W-1:0]     ram_rd_data;
   logic [ID_W-1:0]     rdv;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ID_W-1:0]     wr_data;
   logic                req_in_range;
   logic                out_free;
   logic [ID_W-1:0]     sel_id;
   logic [ID_W-1:0]     sel_id_m1;
   logic [PROD_W-1:0]   prod;

   // entries never written since init read as their reset link
   assign rdv = vld_q_ff ? ram_rd_data : ID_W'(addr_q_ff) + ID_W'(1);

   assign req_in_range = (req_slot_id != '0) && (req_slot_id <= ID_W'(slot_count));

   always_comb begin
      case (cmd.rd_sel)
         RD_REQ: begin
            // allocate reads the head entry, list starts at slot one
            if (op_type'(req_operation) == OP_LIST) begin
               rd_addr = ADDR_W'(1);
            end else if (op_type'(req_operation) != OP_ALLOC && req_in_range) begin
               rd_addr = req_slot_id[ADDR_W-1:0];
            end else begin
               rd_addr = '0;
            end
         end
         RD_ZERO: rd_addr = '0;
         RD_DATA: rd_addr = rdv[ADDR_W-1:0];
         RD_NEXT: rd_addr = idx_ff + ADDR_W'(1);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_HEAD_LINK: begin
            wr_addr = '0;
            wr_data = rdv;
         end
         WR_CLEAR: begin
            wr_addr = head_ff[ADDR_W-1:0];
            wr_data = '0;
         end
         WR_FREE_LINK: begin
            wr_addr = id_ff[ADDR_W-1:0];
            wr_data = rdv;
         end
         WR_FREE_HEAD: begin
            wr_addr = '0;
            wr_data = id_ff;
         end
         default: begin
            wr_addr = '0;
            wr_data = '0;
         end
      endcase
   end

   sfla_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_SLOTS + 1)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset || init) begin
         vld_ff <= '0;
      end else if (cmd.wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.start) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.pend_load) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         vld_q_ff  <= vld_ff[rd_addr];
         addr_q_ff <= rd_addr;
      end
      if (cmd.rd_en && cmd.rd_sel == RD_DATA) begin
         head_ff <= rdv;
      end
      if (cmd.start) begin
         op_ff  <= op_type'(req_operation);
         id_ff  <= req_slot_id;
         idx_ff <= ADDR_W'(1);
      end else if (cmd.rd_en && cmd.rd_sel == RD_NEXT) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (cmd.pend_load) begin
         pend_id_ff <= idx_ff;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (cmd.id_sel)
         ID_HEAD: sel_id = head_ff;
         ID_REQ:  sel_id = id_ff;
         ID_PEND: sel_id = ID_W'(pend_id_ff);
         default: sel_id = '0;
      endcase
   end

   assign sel_id_m1 = sel_id - ID_W'(1);
   assign prod      = PROD_W'(slot_size) * PROD_W'(sel_id_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff    <= cmd.emit_status;
         result_id_ff <= sel_id;
         offset_ff    <= (cmd.id_sel == ID_NONE) ? '0 : prod[OFFSET_W-1:0];
         valid_res_ff <= cmd.id_sel != ID_NONE;
         last_ff      <= cmd.emit_last;
      end
   end

   assign sts.op         = op_ff;
   assign sts.id_ok      = (id_ff != '0) && (id_ff <= ID_W'(slot_count));
   assign sts.rd_zero    = rdv == '0;
   assign sts.head_ok    = (rdv != '0) && (rdv <= ID_W'(slot_count));
   assign sts.list_end   = ID_W'(idx_ff) == ID_W'(slot_count);
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_result_id = result_id_ff;
   assign rsp_offset    = offset_ff;
   assign rsp_valid_res = valid_res_ff;
   assign rsp_last      = last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded while output register is occupied");

   a_no_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_result_id == '0 && rsp_offset == '0))
      else $error("result without slot carries nonzero id or offset");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (int'(wr_addr) <= MAX_SLOTS))
      else $error("link table write outside the pool");

   a_init_clear: assert property (@(posedge clock) disable iff (reset)
      init |=> (vld_ff == '0))
      else $error("valid bits not cleared on re-initialization");

endmodule

// ===== sv/slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// slot_free_list_allocator
// Free list allocator over a numbered slot pool with a link table; allocate,
// free, query and list of used slots, with byte offsets per slot.
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     operation, slot_id
//   rsp       out        rsp_valid / rsp_stall     status, result_id, offset,
//                                                  valid_res, last
//   csr       in/out     psel, penable, pready     slot_count, slot_size
//
// One item at a time, paced by the single link table read port; a list reads
// every slot up to slot_count, and waits out output stalls.
// Reset and a slot_count write mark every table entry unwritten at once; no
// clearing pass. A new item is taken while the last result waits in the
// output register; rsp_stall holds the sequencer only when it must transfer.
// ----------------------------------------------------------------------------
module slot_free_list_allocator import sfla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [ID_W-1:0]       req_slot_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [ID_W-1:0]       rsp_result_id,
   output logic [OFFSET_W-1:0]   rsp_offset,
   output logic                  rsp_valid_res,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [COUNT_W-1:0] slot_count;
   logic [SIZE_W-1:0]  slot_size;
   logic               init;
   cmd_type            cmd;
   sts_type            sts;

   sfla_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .slot_count (slot_count),
      .slot_size  (slot_size),
      .init       (init)
   );

   sfla_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   sfla_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_operation),
      .req_slot_id   (req_slot_id),
      .slot_count    (slot_count),
      .slot_size     (slot_size),
      .init          (init),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_result_id (rsp_result_id),
      .rsp_offset    (rsp_offset),
      .rsp_valid_res (rsp_valid_res),
      .rsp_last      (rsp_last)
   );

endmodule
